// File: rtl/core/lzbd_pkg.sv
package lzbd_pkg;

    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int SIZE_BITS_DEF     = 20;

    // Register indexes on the configuration channel.
    localparam logic [2:0] REG_COUNT_WIDTH = 3'd0;
    localparam logic [2:0] REG_SHORT_WIDTH = 3'd1;
    localparam logic [2:0] REG_LONG_WIDTH  = 3'd2;
    localparam logic [2:0] REG_SIZE_KNOWN  = 3'd3;
    localparam logic [2:0] REG_EXP_SIZE    = 3'd4;

    // End-of-stream status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_DIST = 2'd1;
    localparam logic [1:0] ST_TRUNC    = 2'd2;

    typedef enum logic [2:0] {
        PH_PREFIX1,
        PH_PREFIX2,
        PH_SHORT,
        PH_LONG,
        PH_COUNT,
        PH_LIT
    } phase_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_COPY_RD,
        S_COPY_WAIT,
        S_EOI
    } seq_state_t;

    // Clamp a register value into [lo, hi].
    function automatic logic [3:0] clamp_w(input logic [3:0] v, input logic [3:0] lo,
                                          input logic [3:0] hi);
        logic [3:0] r;
        r = v;
        if (v < lo)
        begin
            r = lo;
        end
        else if (v > hi)
        begin
            r = hi;
        end
        return r;
    endfunction

endpackage

// File: rtl/core/lzbd_history.sv
module lzbd_history #(
    parameter int DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [7:0]    wr_data,
    input  logic [AW-1:0] rd_addr,
    output logic [7:0]    rd_data
);
    logic [7:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule

// File: rtl/core/lz_bit_token_decompressor.sv
// Channel   Direction  Transfer carries
// s_axis    in         tdata: in_byte; tuser: start_of_stream, end_of_input
// m_axis    out        tdata: data_byte, status, consumed_bytes; tuser: kind; tlast
// cfg       in         register index and write data
//
// Each input byte is accepted in S_IDLE and then parsed one bit per cycle in S_BIT,
// unless a copy runs or a stalled output holds the sequencer. Each copied byte passes
// S_COPY_RD, which issues the history read, and S_COPY_WAIT, where the data returns
// from the RAM. An end report is given from S_EOI. Reset is asynchronous, active low,
// and clears all control state; the history RAM is not cleared since it is never read
// before being written. A result is held back while later bits of the same byte may
// still produce another, so that tlast marks the last result of the byte. A stalled
// output holds the sequencer only when it has a result to give; the input is taken
// only when the sequencer is idle and the result register is empty.
module lz_bit_token_decompressor #(
    parameter int HISTORY_DEPTH = lzbd_pkg::HISTORY_DEPTH_DEF,
    parameter int SIZE_BITS     = lzbd_pkg::SIZE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic [1:0]  s_axis_tuser,   // [0] start_of_stream, [1] end_of_input
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [7:0] data_byte, [9:8] status,
                                        // [29:10] consumed_bytes, rest zero
    output logic        m_axis_tuser,   // [0] kind
    output logic        m_axis_tlast,   // last_of_run
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [19:0] cfg_data
);
    import lzbd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam logic [SIZE_BITS-1:0] CMAX = {SIZE_BITS{1'b1}};

    // Configuration registers.
    logic [2:0]  cw_reg;
    logic [3:0]  sw_reg, lw_reg;
    logic        sk_reg;
    logic [19:0] exp_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg  <= 3'd4;
            sw_reg  <= 4'd8;
            lw_reg  <= 4'd11;
            sk_reg  <= 1'b0;
            exp_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_COUNT_WIDTH: cw_reg  <= cfg_data[2:0];
                REG_SHORT_WIDTH: sw_reg  <= cfg_data[3:0];
                REG_LONG_WIDTH:  lw_reg  <= cfg_data[3:0];
                REG_SIZE_KNOWN:  sk_reg  <= cfg_data[0];
                REG_EXP_SIZE:    exp_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    logic [3:0] sw_c, lw_c, cw_c;
    assign sw_c = clamp_w(sw_reg, 4'd1, 4'd10);
    assign lw_c = clamp_w(lw_reg, 4'd1, 4'd11);
    assign cw_c = clamp_w({1'b0, cw_reg}, 4'd1, 4'd4);

    // Stream state.
    seq_state_t state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [11:0] acc_reg, acc_next;
    logic [3:0]  left_reg, left_next;
    logic [11:0] pdist_reg, pdist_next;
    logic        fin_reg, fin_next;
    logic [SIZE_BITS-1:0] ocnt_reg, ocnt_next, icnt_reg, icnt_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [7:0]  byte_reg, byte_next;
    logic        eoi_reg, eoi_next;
    logic [2:0]  bit_reg, bit_next;
    logic [4:0]  copy_reg, copy_next;

    // Output register. While hold_reg is set the result is kept back because
    // later bits of the same byte may still produce another result.
    logic        ov_reg, ov_next;
    logic        hold_reg, hold_next;
    logic        okind_reg, okind_next;
    logic [7:0]  odata_reg, odata_next;
    logic [1:0]  ost_reg, ost_next;
    logic [19:0] ocons_reg, ocons_next;
    logic        olast_reg, olast_next;

    logic         mem_we;
    logic [AW-1:0] mem_wa, mem_ra;
    logic [7:0]   mem_wd, mem_rd;

    lzbd_history #(.DEPTH(HISTORY_DEPTH), .AW(AW)) u_hist (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (mem_wa),
        .wr_data (mem_wd),
        .rd_addr (mem_ra),
        .rd_data (mem_rd)
    );

    assign s_axis_tready = (state_reg == S_IDLE) && !ov_reg;
    assign m_axis_tvalid = ov_reg && !hold_reg;
    assign m_axis_tuser  = okind_reg;
    assign m_axis_tlast  = olast_reg;
    assign m_axis_tdata  = {2'b00, ocons_reg, ost_reg, odata_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= PH_PREFIX1;
            acc_reg   <= '0;
            left_reg  <= '0;
            pdist_reg <= '0;
            fin_reg   <= 1'b0;
            ocnt_reg  <= '0;
            icnt_reg  <= '0;
            wp_reg    <= '0;
            eoi_reg   <= 1'b0;
            bit_reg   <= '0;
            copy_reg  <= '0;
            ov_reg    <= 1'b0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            acc_reg   <= acc_next;
            left_reg  <= left_next;
            pdist_reg <= pdist_next;
            fin_reg   <= fin_next;
            ocnt_reg  <= ocnt_next;
            icnt_reg  <= icnt_next;
            wp_reg    <= wp_next;
            eoi_reg   <= eoi_next;
            bit_reg   <= bit_next;
            copy_reg  <= copy_next;
            ov_reg    <= ov_next;
            hold_reg  <= hold_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        okind_reg <= okind_next;
        odata_reg <= odata_next;
        ost_reg   <= ost_next;
        ocons_reg <= ocons_next;
        olast_reg <= olast_next;
    end

    always_comb
    begin
        logic        out_free;
        logic        b;
        logic [11:0] acc_b;
        logic [3:0]  left_b;
        logic        reached;
        logic        last_bit;
        logic        field_done;
        logic        bad_dist;
        logic        produces;
        logic [SIZE_BITS-1:0] dist_ext;
        logic [AW-1:0] dist_mod;

        state_next = state_reg;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        left_next  = left_reg;
        pdist_next = pdist_reg;
        fin_next   = fin_reg;
        ocnt_next  = ocnt_reg;
        icnt_next  = icnt_reg;
        wp_next    = wp_reg;
        byte_next  = byte_reg;
        eoi_next   = eoi_reg;
        bit_next   = bit_reg;
        copy_next  = copy_reg;
        ov_next    = ov_reg;
        hold_next  = hold_reg;
        okind_next = okind_reg;
        odata_next = odata_reg;
        ost_next   = ost_reg;
        ocons_next = ocons_reg;
        olast_next = olast_reg;
        mem_we     = 1'b0;
        mem_wa     = wp_reg;
        mem_wd     = '0;

        out_free = !ov_reg || (m_axis_tready && !hold_reg);
        if (ov_reg && m_axis_tready && !hold_reg)
        begin
            ov_next = 1'b0;
        end

        reached  = sk_reg && (ocnt_reg >= SIZE_BITS'(exp_reg));
        b        = byte_reg[bit_reg];
        last_bit = (bit_reg == 3'd0);
        acc_b    = {acc_reg[10:0], b};
        left_b   = (left_reg != 4'd0) ? left_reg - 4'd1 : 4'd0;
        dist_ext = SIZE_BITS'(pdist_reg);
        dist_mod = AW'(pdist_reg);
        mem_ra   = wp_reg - dist_mod;

        // A bit produces a result when it ends a literal or a count field
        // whose distance is invalid.
        field_done = (phase_reg != PH_PREFIX1) && (phase_reg != PH_PREFIX2) &&
                     (left_b == 4'd0);
        bad_dist   = (pdist_reg == 12'd0) || (dist_ext > ocnt_reg);
        produces   = field_done &&
                     ((phase_reg == PH_LIT) || ((phase_reg == PH_COUNT) && bad_dist));

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid && s_axis_tready)
                begin
                    if (s_axis_tuser[0])
                    begin
                        phase_next = PH_PREFIX1;
                        acc_next   = '0;
                        left_next  = '0;
                        pdist_next = '0;
                        fin_next   = 1'b0;
                        ocnt_next  = '0;
                        icnt_next  = '0;
                        wp_next    = '0;
                    end
                    byte_next = s_axis_tdata;
                    eoi_next  = s_axis_tuser[1];
                    bit_next  = 3'd7;
                    if (!(fin_reg && !s_axis_tuser[0]))
                    begin
                        if (!s_axis_tuser[0] && reached)
                        begin
                            ov_next    = 1'b1;
                            okind_next = 1'b1;
                            odata_next = '0;
                            ost_next   = ST_OK;
                            ocons_next = 20'(icnt_reg);
                            olast_next = 1'b1;
                            fin_next   = 1'b1;
                        end
                        else if (s_axis_tuser[0] && sk_reg && exp_reg == 20'd0)
                        begin
                            ov_next    = 1'b1;
                            okind_next = 1'b1;
                            odata_next = '0;
                            ost_next   = ST_OK;
                            ocons_next = '0;
                            olast_next = 1'b1;
                            fin_next   = 1'b1;
                        end
                        else
                        begin
                            icnt_next  = s_axis_tuser[0] ? SIZE_BITS'(1) :
                                         (icnt_reg != CMAX ? icnt_reg + 1'b1 : icnt_reg);
                            state_next = S_BIT;
                        end
                    end
                end
            end

            S_BIT:
            begin
                if (produces && hold_reg)
                begin
                    // Another result follows, so the held one is not the last.
                    hold_next = 1'b0;
                end
                else if (!produces || out_free)
                begin
                    priority case (phase_reg)
                        PH_PREFIX1:
                        begin
                            phase_next = b ? PH_PREFIX2 : PH_SHORT;
                            left_next  = b ? left_reg : sw_c;
                            acc_next   = '0;
                        end
                        PH_PREFIX2:
                        begin
                            phase_next = b ? PH_LIT : PH_LONG;
                            left_next  = b ? 4'd8 : lw_c;
                            acc_next   = '0;
                        end
                        default:
                        begin
                            acc_next  = acc_b;
                            left_next = left_b;
                        end
                    endcase
                    if (field_done)
                    begin
                        priority case (phase_reg)
                            PH_SHORT, PH_LONG:
                            begin
                                pdist_next = acc_b + 12'd2 +
                                    ((phase_reg == PH_LONG) ? (12'd1 << sw_c) : 12'd0);
                                phase_next = PH_COUNT;
                                left_next  = cw_c;
                                acc_next   = '0;
                            end
                            PH_COUNT:
                            begin
                                phase_next = PH_PREFIX1;
                                pdist_next = pdist_reg;
                                if (bad_dist)
                                begin
                                    ov_next    = 1'b1;
                                    okind_next = 1'b1;
                                    odata_next = '0;
                                    ost_next   = ST_BAD_DIST;
                                    ocons_next = 20'(icnt_reg);
                                    olast_next = 1'b1;
                                    fin_next   = 1'b1;
                                    state_next = S_IDLE;
                                end
                                else
                                begin
                                    copy_next  = 5'(acc_b[3:0]) + 5'd2;
                                    state_next = S_COPY_RD;
                                end
                            end
                            default:
                            begin
                                phase_next = PH_PREFIX1;
                                mem_we     = 1'b1;
                                mem_wd     = acc_b[7:0];
                                wp_next    = wp_reg + 1'b1;
                                ocnt_next  = (ocnt_reg != CMAX) ? ocnt_reg + 1'b1 : ocnt_reg;
                                ov_next    = 1'b1;
                                okind_next = 1'b0;
                                odata_next = acc_b[7:0];
                                ost_next   = ST_OK;
                                ocons_next = '0;
                                // Literal: check size, then continue or end.
                                if (sk_reg && ocnt_next >= SIZE_BITS'(exp_reg))
                                begin
                                    olast_next = 1'b0;
                                    state_next = S_EOI;
                                    eoi_next   = 1'b0;
                                    fin_next   = 1'b1;
                                end
                                else
                                begin
                                    olast_next = last_bit && !eoi_reg;
                                    hold_next  = !last_bit;
                                    if (last_bit)
                                    begin
                                        state_next = eoi_reg ? S_EOI : S_IDLE;
                                    end
                                end
                            end
                        endcase
                    end
                    if (state_next == S_BIT)
                    begin
                        if (last_bit)
                        begin
                            state_next = eoi_reg ? S_EOI : S_IDLE;
                        end
                    end
                    // The byte ends without a further result: release the held one.
                    if (hold_reg && !produces && last_bit && state_next != S_COPY_RD)
                    begin
                        hold_next  = 1'b0;
                        olast_next = (state_next == S_IDLE);
                    end
                    bit_next = bit_reg - 3'd1;
                end
            end

            S_COPY_RD:
            begin
                // Issue the history read for the next copied byte.
                if (reached || copy_reg == 5'd0)
                begin
                    if (reached)
                    begin
                        fin_next   = 1'b1;
                        eoi_next   = 1'b0;
                        state_next = S_EOI;
                    end
                    else if (bit_reg == 3'd7)
                    begin
                        // The last bit of the byte was consumed by the count field.
                        state_next = eoi_reg ? S_EOI : S_IDLE;
                    end
                    else
                    begin
                        state_next = S_BIT;
                    end
                end
                else
                begin
                    state_next = S_COPY_WAIT;
                end
            end

            S_COPY_WAIT:
            begin
                // The read address stays put, so a stalled cycle reads the same entry.
                if (hold_reg)
                begin
                    hold_next = 1'b0;
                end
                else if (out_free)
                begin
                    mem_we     = 1'b1;
                    mem_wd     = mem_rd;
                    wp_next    = wp_reg + 1'b1;
                    ocnt_next  = (ocnt_reg != CMAX) ? ocnt_reg + 1'b1 : ocnt_reg;
                    copy_next  = copy_reg - 5'd1;
                    ov_next    = 1'b1;
                    okind_next = 1'b0;
                    odata_next = mem_rd;
                    ost_next   = ST_OK;
                    ocons_next = '0;
                    olast_next = 1'b0;
                    state_next = S_COPY_RD;
                    // The final copied byte ends the byte's results unless a report
                    // or later bits of the byte follow.
                    if (copy_reg == 5'd1 && !(sk_reg && ocnt_next >= SIZE_BITS'(exp_reg)))
                    begin
                        if (bit_reg == 3'd7)
                        begin
                            olast_next = !eoi_reg;
                        end
                        else
                        begin
                            hold_next = 1'b1;
                        end
                    end
                end
            end

            S_EOI:
            begin
                // Final report: size reached (fin set) or end of input.
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    okind_next = 1'b1;
                    odata_next = '0;
                    ost_next   = (!fin_reg && sk_reg) ? ST_TRUNC : ST_OK;
                    ocons_next = 20'(icnt_reg);
                    olast_next = 1'b1;
                    fin_next   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end
endmodule

// File: tb/lz_bit_token_decompressor_tb.sv
`timescale 1ns / 1ps

// Testbench for the LZ bit-token decompressor.
// A driver pushes compressed bytes from a queue, a monitor checks every result
// transfer against a behavioral model of the token parser and history buffer.
module lz_bit_token_decompressor_tb;
    import lzbd_pkg::*;

    localparam int HDEPTH = 4096;
    localparam int CMAX   = (1 << 20) - 1;
    localparam int STALL_LIMIT = 20000;
    localparam int HOLD_CYCLES = 300;

    typedef struct packed {
        logic [7:0] byte_val;
        logic       sos;
        logic       eoi;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  data_byte;
        logic [1:0]  status;
        logic [19:0] consumed;
        logic        last;
    } result_t;

    logic clk;
    logic rst_n;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata;
    logic [1:0] s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic m_axis_tuser;
    logic m_axis_tlast;
    logic cfg_valid;
    logic cfg_ready;
    logic [2:0] cfg_index;
    logic [19:0] cfg_data;

    lz_bit_token_decompressor DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // Stimulus queue and the queue of decompressed results still owed.
    in_item_t byte_queue[$];
    result_t  owed_results[$];
    int       error_count = 0;
    int       bytes_sent = 0;
    int       results_seen = 0;
    int       reports_seen = 0;
    bit       hold_output = 1'b0;
    bit       hold_start = 1'b0;
    int       idle_cycles = 0;

    // Model copy of the configuration and the stream state.
    logic [2:0]  m_count_w;
    logic [3:0]  m_short_w;
    logic [3:0]  m_long_w;
    logic        m_sized;
    logic [19:0] m_exp_size;
    logic [7:0]  m_hist[HDEPTH];
    int          m_wr;
    int          m_out_cnt;
    int          m_in_cnt;
    phase_t      m_phase;
    int          m_accum;
    int          m_bits_left;
    int          m_dist;
    bit          m_done;

    // Configuration as seen by the stream builder (set on each width write).
    int m_count_w_cfg = 4;
    int m_short_w_cfg = 8;
    int m_long_w_cfg = 11;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch on %s: got %0d, expected %0d (at %0t)", what, got, want, $time);
        error_count++;
    endtask

    function automatic int clampi(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic bit size_hit();
        return m_sized && m_out_cnt >= m_exp_size;
    endfunction

    function automatic void owe(input logic k, input logic [7:0] d, input logic [1:0] s,
                                input int c);
        result_t r;
        r.kind = k;
        r.data_byte = d;
        r.status = s;
        r.consumed = c[19:0];
        r.last = 1'b0;
        owed_results = {owed_results, r};
    endfunction

    function automatic void emit_byte(input logic [7:0] v);
        m_hist[m_wr] = v;
        m_wr = (m_wr + 1) % HDEPTH;
        if (m_out_cnt < CMAX)
            m_out_cnt++;
        owe(1'b0, v, ST_OK, 0);
    endfunction

    function automatic void end_stream(input logic [1:0] st);
        owe(1'b1, 8'd0, st, m_in_cnt);
        m_done = 1'b1;
    endfunction

    function automatic void close_token();
        m_phase = PH_PREFIX1;
        if (size_hit())
            end_stream(ST_OK);
    endfunction

    function automatic void reset_stream();
        m_wr = 0;
        m_out_cnt = 0;
        m_in_cnt = 0;
        m_phase = PH_PREFIX1;
        m_accum = 0;
        m_bits_left = 0;
        m_dist = 0;
        m_done = 1'b0;
    endfunction

    // Feeds one bit to the token parser.
    function automatic void parse_bit(input bit b);
        int sw;
        int lw;
        int cw;
        int src;
        sw = clampi(m_short_w, 1, 10);
        lw = clampi(m_long_w, 1, 11);
        cw = clampi(m_count_w, 1, 4);
        if (m_phase == PH_PREFIX1)
        begin
            if (!b)
            begin
                m_phase = PH_SHORT;
                m_bits_left = sw;
            end
            else
                m_phase = PH_PREFIX2;
            m_accum = 0;
            return;
        end
        if (m_phase == PH_PREFIX2)
        begin
            if (!b)
            begin
                m_phase = PH_LONG;
                m_bits_left = lw;
            end
            else
            begin
                m_phase = PH_LIT;
                m_bits_left = 8;
            end
            m_accum = 0;
            return;
        end
        m_accum = ((m_accum << 1) | b) & 12'hFFF;
        if (m_bits_left > 0)
            m_bits_left--;
        if (m_bits_left != 0)
            return;
        if (m_phase == PH_SHORT || m_phase == PH_LONG)
        begin
            m_dist = m_accum + 2;
            if (m_phase == PH_LONG)
                m_dist += 1 << sw;
            m_dist &= 12'hFFF;
            m_phase = PH_COUNT;
            m_bits_left = cw;
            m_accum = 0;
        end
        else if (m_phase == PH_COUNT)
        begin
            if (m_dist == 0 || m_dist > m_out_cnt)
            begin
                end_stream(ST_BAD_DIST);
                return;
            end
            for (int i = 0; i < m_accum + 2; i++)
            begin
                if (size_hit())
                    break;
                src = (m_wr + HDEPTH - (m_dist % HDEPTH)) % HDEPTH;
                emit_byte(m_hist[src]);
            end
            close_token();
        end
        else
        begin
            emit_byte(m_accum[7:0]);
            close_token();
        end
    endfunction

    // Works out every result that one accepted compressed byte causes.
    function automatic void predict_byte(input in_item_t it);
        int first;
        first = owed_results.size();
        if (it.sos)
            reset_stream();
        if (m_done)
            return;
        if (size_hit())
            end_stream(ST_OK);
        else
        begin
            if (m_in_cnt < CMAX)
                m_in_cnt++;
            for (int k = 7; k >= 0 && !m_done; k--)
                parse_bit(it.byte_val[k]);
            if (!m_done && it.eoi)
                end_stream(m_sized ? ST_TRUNC : ST_OK);
        end
        if (owed_results.size() > first)
            owed_results[owed_results.size() - 1].last = 1'b1;
    endfunction

    // Driver: inputs change on the falling edge; a random gap precedes each byte.
    int send_gap = 0;
    bit in_taken = 1'b0;
    always @(negedge clk)
    begin
        in_taken <= 1'b0;
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (s_axis_tvalid && !in_taken)
            ;
        else if (send_gap > 0)
        begin
            send_gap <= send_gap - 1;
            s_axis_tvalid <= 1'b0;
        end
        else if (byte_queue.size() > 0)
        begin
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= byte_queue[0].byte_val;
            s_axis_tuser <= {byte_queue[0].eoi, byte_queue[0].sos};
        end
        else
            s_axis_tvalid <= 1'b0;
    end

    // Prediction happens at the accepting edge; the queue entry is then retired.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            predict_byte(byte_queue.pop_front());
            bytes_sent++;
            in_taken <= 1'b1;
            send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
    end

    // Long receiver hold, counted here once the stimulus asks for it.
    always
    begin
        @(posedge hold_start);
        hold_output = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_output = 1'b0;
    end

    // Receiver ready: random stall per result, or held low by the pressure phase.
    int recv_gap = 0;
    always @(negedge clk)
    begin
        if (!rst_n || hold_output)
            m_axis_tready <= 1'b0;
        else if (recv_gap > 0)
        begin
            recv_gap <= recv_gap - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Monitor: compares each result transfer with the oldest owed result.
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (m_axis_tuser)
                reports_seen++;
            if (owed_results.size() == 0)
                report_mismatch("unexpected result transfer", 1, 0);
            else
            begin
                want = owed_results.pop_front();
                if (m_axis_tuser !== want.kind)
                    report_mismatch("kind", m_axis_tuser, want.kind);
                if (m_axis_tdata[7:0] !== want.data_byte)
                    report_mismatch("data_byte", m_axis_tdata[7:0], want.data_byte);
                if (m_axis_tdata[9:8] !== want.status)
                    report_mismatch("status", m_axis_tdata[9:8], want.status);
                if (m_axis_tdata[29:10] !== want.consumed)
                    report_mismatch("consumed_bytes", m_axis_tdata[29:10], want.consumed);
                if (m_axis_tlast !== want.last)
                    report_mismatch("last_of_run", m_axis_tlast, want.last);
            end
            recv_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        end
    end

    // Watchdog: counts cycles in which no transfer happens on any channel.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
            $display("[lz_bit_token_decompressor] ERROR");
            $finish;
        end
    end

    // Bit packer used to build well-formed token streams.
    bit token_bits[$];

    task automatic push_field(input int v, input int width);
        for (int k = width - 1; k >= 0; k--)
            token_bits = {token_bits, v[k]};
    endtask

    // Turns the collected bits into bytes; the tail is filled with random bits.
    task automatic flush_bits(input bit sos, input bit eoi);
        in_item_t it;
        int nbytes;
        nbytes = (token_bits.size() + 7) / 8;
        if (nbytes == 0)
            nbytes = 1;
        for (int b = 0; b < nbytes; b++)
        begin
            for (int k = 7; k >= 0; k--)
                it.byte_val[k] = (token_bits.size() > 0) ? token_bits.pop_front()
                                                          : $urandom_range(0, 1);
            it.sos = sos && b == 0;
            it.eoi = eoi && b == nbytes - 1;
            byte_queue = {byte_queue, it};
        end
    endtask

    task automatic push_raw(input logic [7:0] v, input bit sos, input bit eoi);
        in_item_t it;
        it.byte_val = v;
        it.sos = sos;
        it.eoi = eoi;
        byte_queue = {byte_queue, it};
    endtask

    // Builds one stream: at least two literals first, then literals mixed with
    // back-references whose distance stays within the output so far; an occasional broken one.
    task automatic build_stream(input int ntokens, input bit allow_bad);
        int produced;
        int sw;
        int lw;
        int cw;
        int d;
        int sel;
        produced = 0;
        sw = clampi(m_short_w_cfg, 1, 10);
        lw = clampi(m_long_w_cfg, 1, 11);
        cw = clampi(m_count_w_cfg, 1, 4);
        for (int t = 0; t < ntokens; t++)
        begin
            sel = $urandom_range(0, 9);
            if (produced < 2 || sel < 4)
            begin
                push_field(3, 2);
                push_field($urandom_range(0, 255), 8);
                produced++;
            end
            else if (sel < 8 || produced < (1 << sw) + 2)
            begin
                d = $urandom_range(0, clampi(produced - 2, 0, (1 << sw) - 1));
                if (allow_bad && $urandom_range(0, 15) == 0)
                    d = (1 << sw) - 1;
                push_field(0, 1);
                push_field(d, sw);
                push_field($urandom_range(0, (1 << cw) - 1), cw);
                produced += 2;
            end
            else
            begin
                d = $urandom_range(0, clampi(produced - 2 - (1 << sw), 0, (1 << lw) - 1));
                push_field(2, 2);
                push_field(d, lw);
                push_field($urandom_range(0, (1 << cw) - 1), cw);
                produced += 2;
            end
        end
        flush_bits(1'b1, $urandom_range(0, 3) != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [19:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            REG_COUNT_WIDTH: begin m_count_w = val[2:0]; m_count_w_cfg = val[2:0]; end
            REG_SHORT_WIDTH: begin m_short_w = val[3:0]; m_short_w_cfg = val[3:0]; end
            REG_LONG_WIDTH:  begin m_long_w = val[3:0]; m_long_w_cfg = val[3:0]; end
            REG_SIZE_KNOWN:  m_sized = val[0];
            REG_EXP_SIZE:    m_exp_size = val;
            default: ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Waits for the block to drain, including bytes that give no result.
    task automatic drain();
        while (byte_queue.size() > 0 || owed_results.size() > 0 || s_axis_tvalid)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic set_widths(input int cw, input int sw, input int lw, input bit sized,
                              input int exp_sz);
        write_reg(REG_COUNT_WIDTH, 20'(cw));
        write_reg(REG_SHORT_WIDTH, 20'(sw));
        write_reg(REG_LONG_WIDTH, 20'(lw));
        write_reg(REG_SIZE_KNOWN, 20'(sized));
        write_reg(REG_EXP_SIZE, 20'(exp_sz));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'd0;
        s_axis_tuser = 2'd0;
        m_axis_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_COUNT_WIDTH;
        cfg_data = 20'd0;
        m_count_w = 3'd4;
        m_short_w = 4'd8;
        m_long_w = 4'd11;
        m_sized = 1'b0;
        m_exp_size = 20'd0;
        for (int i = 0; i < HDEPTH; i++)
            m_hist[i] = 8'd0;
        reset_stream();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: reset settings, short streams built from all-ones and all-zeros bytes.
        push_raw(8'hFF, 1'b1, 1'b0);        // literal 0xFF after the prefix bits
        push_raw(8'hC0, 1'b0, 1'b0);
        push_raw(8'h00, 1'b0, 1'b1);        // short copy with distance 2 > 1 output byte: bad
        push_raw(8'hAA, 1'b0, 1'b0);        // ignored after finish
        push_raw(8'h00, 1'b1, 1'b1);        // distance field unfinished when input ends: OK report
        drain();

        // Small widths with clamping (zero and out-of-range values), sized mode.
        set_widths(0, 0, 0, 1, 3);
        push_raw(8'hFF, 1'b1, 1'b0);
        push_raw(8'hFF, 1'b0, 1'b0);
        push_raw(8'hFF, 1'b0, 1'b0);
        push_raw(8'h00, 1'b0, 1'b0);        // size reached within this byte
        push_raw(8'h11, 1'b0, 1'b0);
        drain();
        set_widths(7, 15, 15, 1, 0);        // expected size zero: immediate report
        push_raw(8'h5A, 1'b1, 1'b0);
        push_raw(8'h7F, 1'b1, 1'b1);
        drain();
        set_widths(1, 1, 1, 1, 40);         // sized stream that runs out of input
        build_stream(6, 1'b0);
        byte_queue[byte_queue.size() - 1].eoi = 1'b1;
        drain();

        // Pressure: hold the receiver while long copies fill the block.
        set_widths(4, 2, 3, 0, 20'hFFFFF);
        hold_start = 1'b1;
        build_stream(10, 1'b0);
        @(posedge clk);
        wait (!hold_output);
        hold_start = 1'b0;
        drain();

        // Random phases over several settings.
        for (int ph = 0; ph < 5; ph++)
        begin
            case (ph)
                0: set_widths(4, 8, 11, 0, 0);
                1: set_widths(2, 3, 5, 1, $urandom_range(5, 40));
                2: set_widths(3, 10, 11, 0, 0);
                3: set_widths(1, 1, 2, 1, 20'hFFFFF);
                default: set_widths($urandom_range(1, 4), $urandom_range(1, 10),
                                    $urandom_range(1, 11), 0, 0);
            endcase
            while (byte_queue.size() < 14)
            begin
                if ($urandom_range(0, 5) == 0)
                    push_raw($urandom_range(0, 255), $urandom_range(0, 1),
                             $urandom_range(0, 1));
                else
                    build_stream($urandom_range(3, 10), 1'b1);
            end
            drain();
        end

        $display("covered %0d compressed bytes, %0d result transfers, %0d end reports",
                 bytes_sent, results_seen, reports_seen);
        $display("settings: default, clamped widths, sized and unbounded, output backpressure");
        if (error_count == 0)
            $display("[lz_bit_token_decompressor] OK");
        else
            $display("[lz_bit_token_decompressor] ERROR");
        $finish;
    end

endmodule

// File: files.f
rtl/core/lzbd_pkg.sv
rtl/core/lzbd_history.sv
rtl/core/lz_bit_token_decompressor.sv
tb/lz_bit_token_decompressor_tb.sv
